/* design/dll_pkg.sv */
// Package for the linked list with undo: request and result types, codes.
// No dependencies.
package dll_pkg;
  localparam int UniverseSize = 64;
  localparam int ElemW = 6;

  localparam logic [2:0] ReqPushFront = 3'd0;
  localparam logic [2:0] ReqPushBack  = 3'd1;
  localparam logic [2:0] ReqPopFront  = 3'd2;
  localparam logic [2:0] ReqPopBack   = 3'd3;
  localparam logic [2:0] ReqRemove    = 3'd4;
  localparam logic [2:0] ReqRollback  = 3'd5;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StEmpty   = 2'd1;
  localparam logic [1:0] StAbsent  = 2'd2;
  localparam logic [1:0] StPresent = 2'd3;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [ElemW-1:0] element;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ElemW-1:0] head_element;
    logic [ElemW-1:0] tail_element;
    logic [6:0]       live_count;
    logic             list_empty;
  } rsp_t;
endpackage

/* design/dancing_links_list_with_undo_top.sv */
// Top level of the linked list with undo; uses dll_pkg and dll_ram.
// Links and the undo stack live in RAMs; flags in flip-flops.
// Busy stays high from the accepting edge to the result strobe. A request refused at
// acceptance (push of an inserted element, remove of an absent one, pop of an empty list,
// rollback of an empty stack) and an unused code go straight to SDone. A push passes SW1
// and SW2, a pop or remove SRd, SW1 and SW2, and a rollback SWait (undo stack read), SRd,
// SW1 and SW2, with a second pass through SW2 when it relinks at the front or the back.
// The cost is set by the registered RAM reads and the number of link entries patched (a
// remove reads both links and patches two neighbours).
// Results appear on rsp_o for one cycle with rsp_valid_o; they cannot be held off.
module dancing_links_list_with_undo_top #(
  parameter int UNIVERSE_SIZE = dll_pkg::UniverseSize
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  dll_pkg::req_t    req_i,
  output logic             busy,
  output logic             rsp_valid_o,
  output dll_pkg::rsp_t    rsp_o
);
  import dll_pkg::*;

  localparam int AW = $clog2(UNIVERSE_SIZE);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] Nil = PW'(UNIVERSE_SIZE);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRd   = 3'd1;
  localparam logic [2:0] SWait = 3'd2;
  localparam logic [2:0] SW1   = 3'd3;
  localparam logic [2:0] SW2   = 3'd4;
  localparam logic [2:0] SW3   = 3'd5;
  localparam logic [2:0] SDone = 3'd6;

  logic [2:0]             st_q, st_d;
  logic [2:0]             op_q, op_d;
  logic [PW-1:0]          x_q, x_d;
  logic [1:0]             stat_q, stat_d;
  logic [PW-1:0]          head_q, head_d, tail_q, tail_d;
  logic [PW-1:0]          cnt_q, cnt_d, depth_q, depth_d;
  logic [UNIVERSE_SIZE-1:0] ins_q, ins_d, lnk_q, lnk_d;
  logic [PW-1:0]          p_q, p_d, n_q, n_d;

  logic          nx_we, pv_we, us_we;
  logic [AW-1:0] nx_wa, pv_wa, us_wa, nx_ra, pv_ra, us_ra;
  logic [PW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic [AW-1:0] us_wd, us_rd;
  logic [PW-1:0] elem_ext;

  dll_ram #(.Width(PW), .Depth(UNIVERSE_SIZE)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(nx_ra), .rdata_o(nx_rd));
  dll_ram #(.Width(PW), .Depth(UNIVERSE_SIZE)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd), .raddr_i(pv_ra), .rdata_o(pv_rd));
  dll_ram #(.Width(AW), .Depth(UNIVERSE_SIZE)) u_undo (
    .clk_i, .we_i(us_we), .waddr_i(us_wa), .wdata_i(us_wd), .raddr_i(us_ra), .rdata_o(us_rd));

  assign busy = (st_q != SIdle);
  assign elem_ext = PW'(req_i.element);

  always_comb begin
    st_d = st_q; op_d = op_q; x_d = x_q; stat_d = stat_q;
    head_d = head_q; tail_d = tail_q; cnt_d = cnt_q; depth_d = depth_q;
    ins_d = ins_q; lnk_d = lnk_q; p_d = p_q; n_d = n_q;
    nx_we = 1'b0; pv_we = 1'b0; us_we = 1'b0;
    nx_wa = x_q[AW-1:0]; pv_wa = x_q[AW-1:0]; us_wa = depth_q[AW-1:0];
    nx_wd = Nil; pv_wd = Nil; us_wd = x_q[AW-1:0];
    nx_ra = x_q[AW-1:0]; pv_ra = x_q[AW-1:0];
    us_ra = AW'(depth_q - PW'(1));
    unique case (st_q)
      SIdle: begin
        if (start) begin
          op_d = req_i.req_type;
          stat_d = StDone;
          st_d = SDone;
          unique case (req_i.req_type)
            ReqPushFront, ReqPushBack: begin
              x_d = elem_ext;
              if (elem_ext >= Nil) stat_d = StAbsent;
              else if (ins_q[elem_ext[AW-1:0]]) stat_d = StPresent;
              else st_d = SW1;
            end
            ReqPopFront: begin
              x_d = head_q;
              if (head_q >= Nil) stat_d = StEmpty; else st_d = SRd;
            end
            ReqPopBack: begin
              x_d = tail_q;
              if (tail_q >= Nil) stat_d = StEmpty; else st_d = SRd;
            end
            ReqRemove: begin
              x_d = elem_ext;
              if (elem_ext >= Nil || !lnk_q[elem_ext[AW-1:0]]) stat_d = StAbsent;
              else st_d = SRd;
            end
            ReqRollback: begin
              if (depth_q == '0) stat_d = StEmpty;
              else begin
                depth_d = depth_q - PW'(1);
                st_d = SWait;
              end
            end
            default: ;
          endcase
        end
      end
      SWait: begin
        x_d = PW'(us_rd);
        st_d = SRd;
      end
      SRd: st_d = SW1;
      SW1: begin
        if (op_q == ReqPushFront || op_q == ReqPushBack) begin
          nx_we = 1'b1; pv_we = 1'b1;
          if (op_q == ReqPushFront) begin
            pv_wd = Nil; nx_wd = head_q;
          end else begin
            nx_wd = Nil; pv_wd = tail_q;
          end
          ins_d[x_q[AW-1:0]] = 1'b1;
          lnk_d[x_q[AW-1:0]] = 1'b1;
          cnt_d = cnt_q + PW'(1);
          p_d = tail_q; n_d = head_q;
          st_d = SW2;
        end else begin
          p_d = pv_rd; n_d = nx_rd;
          st_d = SW2;
        end
      end
      SW2: begin
        st_d = SDone;
        if (op_q == ReqPushFront) begin
          if (n_q < Nil) begin
            pv_we = 1'b1; pv_wa = n_q[AW-1:0]; pv_wd = x_q;
          end else tail_d = x_q;
          head_d = x_q;
        end else if (op_q == ReqPushBack) begin
          if (p_q < Nil) begin
            nx_we = 1'b1; nx_wa = p_q[AW-1:0]; nx_wd = x_q;
          end else head_d = x_q;
          tail_d = x_q;
        end else if (op_q == ReqRollback) begin
          lnk_d[x_q[AW-1:0]] = 1'b1;
          cnt_d = cnt_q + PW'(1);
          if (p_q >= Nil) begin
            op_d = ReqPushFront; n_d = head_q;
            nx_we = 1'b1; nx_wd = head_q;
            st_d = SW2;
          end else if (n_q >= Nil) begin
            op_d = ReqPushBack; p_d = tail_q;
            pv_we = 1'b1; pv_wd = tail_q;
            st_d = SW2;
          end else begin
            nx_we = 1'b1; nx_wa = p_q[AW-1:0]; nx_wd = x_q;
            pv_we = 1'b1; pv_wa = n_q[AW-1:0]; pv_wd = x_q;
          end
        end else begin
          if (p_q < Nil) begin
            nx_we = 1'b1; nx_wa = p_q[AW-1:0]; nx_wd = n_q;
          end else head_d = n_q;
          if (n_q < Nil) begin
            pv_we = 1'b1; pv_wa = n_q[AW-1:0]; pv_wd = p_q;
          end else tail_d = p_q;
          lnk_d[x_q[AW-1:0]] = 1'b0;
          if (cnt_q != '0) cnt_d = cnt_q - PW'(1);
          if (depth_q < Nil) begin
            us_we = 1'b1;
            depth_d = depth_q + PW'(1);
          end
        end
      end
      SDone: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; head_q <= Nil; tail_q <= Nil;
      cnt_q <= '0; depth_q <= '0; ins_q <= '0; lnk_q <= '0;
      op_q <= '0; stat_q <= '0;
    end else begin
      st_q <= st_d; head_q <= head_d; tail_q <= tail_d;
      cnt_q <= cnt_d; depth_q <= depth_d; ins_q <= ins_d; lnk_q <= lnk_d;
      op_q <= op_d; stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; p_q <= p_d; n_q <= n_d;
  end

  assign rsp_valid_o         = (st_q == SDone);
  assign rsp_o.status        = stat_q;
  assign rsp_o.head_element  = (head_q >= Nil) ? '0 : ElemW'(head_q);
  assign rsp_o.tail_element  = (tail_q >= Nil) ? '0 : ElemW'(tail_q);
  assign rsp_o.live_count    = 7'(cnt_q);
  assign rsp_o.list_empty    = (head_q >= Nil);
endmodule

/* design/dll_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module dll_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* design/dll_checker.sv */
// Port-level checks for the linked list with undo; uses dll_pkg.
// Bound to the top level below.
module dll_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          rsp_valid_o,
  input dll_pkg::rsp_t rsp_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("transfer not taken");
  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o) else $error("strobe held");
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.list_empty == (rsp_o.live_count == 7'd0)))
    else $error("empty flag disagrees with count");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.list_empty |-> rsp_o.head_element == '0 && rsp_o.tail_element == '0)
    else $error("empty list shows elements");
endmodule

bind dancing_links_list_with_undo_top dll_checker u_chk (.*);
